// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker: implication failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker: next-cycle implication failed");

`endif

// ===== design/wrs_pkg.sv =====
// types and constants of the waypoint route sequencer
package wrs_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_HOME  = 2'd1;
    localparam logic [1:0] OP_ROUTE = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    localparam logic [1:0] MODE_HOME_AT_END  = 2'd0;
    localparam logic [1:0] MODE_LOOP         = 2'd1;
    localparam logic [1:0] MODE_PINGPONG_END = 2'd2;

    localparam logic [1:0] CFG_CAPTURE_RANGE  = 2'd0;
    localparam logic [1:0] CFG_ROUTE_MODE     = 2'd1;
    localparam logic [1:0] CFG_WAYPOINT_COUNT = 2'd2;
    localparam logic [1:0] CFG_UPLINK_MODE    = 2'd3;

    localparam logic [7:0] TARGET_HOME   = 8'hff;
    localparam logic [7:0] TARGET_UPLINK = 8'hfe;

    localparam int CFG_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] distance;
        logic        uplink_switch;
    } in_word_t;

    typedef struct packed {
        logic [7:0] target_index;
        logic       homing;
        logic       reversed;
        logic       advanced;
    } out_word_t;

    typedef struct packed {
        logic [23:0] capture_range;
        logic [1:0]  route_mode;
        logic [6:0]  waypoint_count;
        logic        uplink_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  route_index;
        logic        go_home;
        logic        reverse;
        logic [23:0] last_distance;
    } route_state_t;

endpackage

// ===== design/wrs_cfg_regs.sv =====
// configuration register file of the waypoint route sequencer
module wrs_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [wrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wrs_pkg::cfg_t                   cfg
);

    wrs_pkg::cfg_t cfg_reg;
    wrs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wrs_pkg::CFG_CAPTURE_RANGE:  cfg_next.capture_range  = cfg_data[23:0];
                wrs_pkg::CFG_ROUTE_MODE:     cfg_next.route_mode     = cfg_data[1:0];
                wrs_pkg::CFG_WAYPOINT_COUNT: cfg_next.waypoint_count = cfg_data[6:0];
                wrs_pkg::CFG_UPLINK_MODE:    cfg_next.uplink_mode    = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/wrs_step.sv =====
// next route state and result word for one input word
module wrs_step #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  wrs_pkg::in_word_t     in_word,
    input  wrs_pkg::cfg_t         cfg,
    input  wrs_pkg::route_state_t state,
    output wrs_pkg::route_state_t state_next,
    output wrs_pkg::out_word_t    result
);

    localparam logic [7:0] MAX_COUNT = 8'(MAX_WAYPOINTS);

    logic [7:0]        eff_count;
    logic signed [9:0] idx_s;
    logic signed [9:0] last_s;
    logic              at_last;
    logic              captured;

    always_comb
    begin
        if ({1'b0, cfg.waypoint_count} > MAX_COUNT)
            eff_count = MAX_COUNT;
        else
            eff_count = {1'b0, cfg.waypoint_count};
        idx_s    = signed'({2'b00, state.route_index});
        last_s   = signed'({2'b00, eff_count}) - 10'sd1;
        // an empty route gives last = -1, so every index counts as the last
        at_last  = (idx_s >= last_s);
        captured = (in_word.distance < cfg.capture_range) &&
                   (state.last_distance < in_word.distance);
    end

    always_comb
    begin
        state_next = state;
        case (in_word.operation)
            wrs_pkg::OP_TICK:
            begin
                if (!state.go_home)
                begin
                    if (captured)
                    begin
                        if (!state.reverse)
                        begin
                            if (at_last)
                            begin
                                case (cfg.route_mode)
                                    wrs_pkg::MODE_HOME_AT_END:
                                        state_next.route_index = wrs_pkg::TARGET_HOME;
                                    wrs_pkg::MODE_LOOP:
                                        state_next.route_index = 8'd0;
                                    default:
                                    begin
                                        state_next.reverse = 1'b1;
                                        if (state.route_index != 8'd0)
                                            state_next.route_index = state.route_index - 8'd1;
                                    end
                                endcase
                            end
                            else
                            begin
                                state_next.route_index = state.route_index + 8'd1;
                            end
                        end
                        else if (state.route_index == 8'd0)
                        begin
                            if (cfg.route_mode == wrs_pkg::MODE_PINGPONG_END)
                            begin
                                state_next.route_index = wrs_pkg::TARGET_HOME;
                            end
                            else
                            begin
                                state_next.reverse = 1'b0;
                                if (!at_last)
                                    state_next.route_index = 8'd1;
                            end
                        end
                        else
                        begin
                            state_next.route_index = state.route_index - 8'd1;
                        end
                    end
                    state_next.last_distance = in_word.distance;
                end
            end
            wrs_pkg::OP_HOME:  state_next.go_home = 1'b1;
            wrs_pkg::OP_ROUTE: state_next.go_home = 1'b0;
            default:
            begin
                state_next.route_index = 8'd0;
                state_next.go_home     = 1'b1;
                state_next.reverse     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cfg.uplink_mode && in_word.uplink_switch)
            result.target_index = wrs_pkg::TARGET_UPLINK;
        else if (state_next.go_home || (state_next.route_index >= eff_count))
            result.target_index = wrs_pkg::TARGET_HOME;
        else
            result.target_index = state_next.route_index;
        result.homing   = state_next.go_home;
        result.reversed = state_next.reverse;
        result.advanced = (state_next.route_index != state.route_index);
    end

endmodule

// ===== design/waypoint_route_sequencer.sv =====
// waypoint route sequencer: top level with input and result registers
//
// in channel (in_valid, in_ready, in_data) takes one word per item: a tick with
// the distance to the current waypoint, go home, do route or initialise.
// out channel (out_valid, out_ready, out_data) gives exactly one result word
// per input word: target index (254 uplink, 255 home), homing, reversed, and
// whether the waypoint index moved.
// configuration is written through cfg_we / cfg_index / cfg_data, one register
// per cycle; the user must write only while no word is in flight, unenforced.
// a word moves from the input register into the result register; out_valid rises
// as it does; one word is accepted every cycle, limited only by out_ready.
// the route state update is a single compare-and-select pass between the
// input register and the result register.
// reset clears the route state (index 0, not homing, forward, last distance
// 0), the configuration and both valid flags.
// when the receiver stalls the result word holds; the input register takes
// one more word and then in_ready drops until the result is taken.
module waypoint_route_sequencer #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wrs_pkg::in_word_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wrs_pkg::out_word_t              out_data,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [wrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wrs_pkg::cfg_t         cfg;
    wrs_pkg::in_word_t     in_word_reg;
    logic                  in_valid_reg;
    wrs_pkg::out_word_t    out_word_reg;
    logic                  out_valid_reg;
    wrs_pkg::route_state_t state_reg;
    wrs_pkg::route_state_t state_next;
    wrs_pkg::out_word_t    result;
    logic                  advance;

    wrs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wrs_step #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_step (
        .in_word    (in_word_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // result register free or being emptied this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
        if (advance && in_valid_reg)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// ===== design/wrs_checker.sv =====
// port-level checker for the waypoint route sequencer, bound to the top level
`include "assert_macros.svh"

module wrs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input wrs_pkg::out_word_t out_data
);

    // a stalled result word holds
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // an empty result register never blocks the input side
    `CHK_IMPLIES(a_ready_when_empty, !out_valid, in_ready)

    // while homing the target is home unless the uplink overrides it
    `CHK_IMPLIES(a_homing_target, out_valid && out_data.homing,
        out_data.target_index == wrs_pkg::TARGET_HOME ||
        out_data.target_index == wrs_pkg::TARGET_UPLINK)

    // a route index at or above the waypoint count shows as home, so target code 253 cannot appear
    `CHK_IMPLIES(a_no_target_253, out_valid, out_data.target_index != 8'd253)

endmodule

bind waypoint_route_sequencer wrs_checker u_wrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
